// ===== hdl/seg_isect_pkg.sv =====
`timescale 1ns / 1ps
package seg_isect_pkg;

   // default coordinate width, in bits
   localparam int COORD_WIDTH_DEF = 16;

endpackage

// ===== hdl/seg_isect_front.sv =====
`timescale 1ns / 1ps
module seg_isect_front #(
   parameter int COORD_WIDTH = seg_isect_pkg::COORD_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic signed [COORD_WIDTH-1:0] s1x,
   input  logic signed [COORD_WIDTH-1:0] s1y,
   input  logic signed [COORD_WIDTH-1:0] e1x,
   input  logic signed [COORD_WIDTH-1:0] e1y,
   input  logic signed [COORD_WIDTH-1:0] s2x,
   input  logic signed [COORD_WIDTH-1:0] s2y,
   input  logic signed [COORD_WIDTH-1:0] e2x,
   input  logic signed [COORD_WIDTH-1:0] e2y,
   output logic                          out_valid,
   output logic [3*(COORD_WIDTH+1)-1:0]  prod_x,
   output logic [3*(COORD_WIDTH+1)-1:0]  prod_y,
   output logic [2*(COORD_WIDTH+1)-1:0]  deno_mag,
   output logic [2*COORD_WIDTH+3:0]      tag
);
   import seg_isect_pkg::*;

   localparam int W   = COORD_WIDTH;
   localparam int DW  = W + 1;
   localparam int PRW = 2 * DW;
   localparam int CW  = PRW + 1;
   localparam int AW  = CW - 1;
   localparam int PW  = AW + DW;

   logic [4:0] vld_ff;

   // stage 1: differences
   logic signed [W-1:0]  s1x_ff, s1y_ff;
   logic signed [DW-1:0] d1x_ff, d1y_ff, d2x_ff, d2y_ff, ex_ff, ey_ff;

   // stage 2: products
   logic signed [W-1:0]   s1x2_ff, s1y2_ff;
   logic signed [DW-1:0]  d1x2_ff, d1y2_ff;
   logic signed [PRW-1:0] p_a_ff, p_b_ff, p_c_ff, p_d_ff, p_e_ff, p_f_ff;

   // stage 3: cross products
   logic signed [W-1:0]  s1x3_ff, s1y3_ff;
   logic signed [DW-1:0] d1x3_ff, d1y3_ff;
   logic signed [CW-1:0] deno_ff, snum_ff, tnum_ff;

   // stage 4: magnitudes, signs and hit test
   logic signed [W-1:0] s1x4_ff, s1y4_ff;
   logic [DW-1:0]       d1x_mag_ff, d1y_mag_ff;
   logic [AW-1:0]       snum_mag_ff, deno_mag_ff;
   logic                neg_x_ff, neg_y_ff, hit_ff, par_ff;

   // stage 5: dividends
   logic [PW-1:0]       prod_x_ff, prod_y_ff;
   logic [AW-1:0]       deno5_ff;
   logic [2*W+3:0]      tag_ff;

   logic signed [CW-1:0] deno_in, snum_in, tnum_in;
   logic                 s_in_unit, t_in_unit;
   logic [CW-1:0]        snum_abs, deno_abs;
   logic [DW-1:0]        d1x_abs, d1y_abs;

   assign deno_in = CW'(p_a_ff) - CW'(p_b_ff);
   assign snum_in = CW'(p_c_ff) - CW'(p_d_ff);
   assign tnum_in = CW'(p_e_ff) - CW'(p_f_ff);

   // range test of both parameters against the denominator
   always_comb begin
      if (deno_ff < 0) begin
         s_in_unit = (deno_ff <= snum_ff) && (snum_ff <= 0);
         t_in_unit = (deno_ff <= tnum_ff) && (tnum_ff <= 0);
      end else begin
         s_in_unit = (snum_ff >= 0) && (snum_ff <= deno_ff);
         t_in_unit = (tnum_ff >= 0) && (tnum_ff <= deno_ff);
      end
   end

   assign snum_abs = (snum_ff < 0) ? CW'(-snum_ff) : CW'(snum_ff);
   assign deno_abs = (deno_ff < 0) ? CW'(-deno_ff) : CW'(deno_ff);
   assign d1x_abs  = (d1x3_ff < 0) ? DW'(-d1x3_ff) : DW'(d1x3_ff);
   assign d1y_abs  = (d1y3_ff < 0) ? DW'(-d1y3_ff) : DW'(d1y3_ff);

   // advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[3:0], in_valid};
      end
   end

   // advance payload
   always_ff @(posedge clock) begin
      if (en) begin
         s1x_ff  <= s1x;
         s1y_ff  <= s1y;
         d1x_ff  <= DW'(e1x) - DW'(s1x);
         d1y_ff  <= DW'(e1y) - DW'(s1y);
         d2x_ff  <= DW'(e2x) - DW'(s2x);
         d2y_ff  <= DW'(e2y) - DW'(s2y);
         ex_ff   <= DW'(s2x) - DW'(s1x);
         ey_ff   <= DW'(s2y) - DW'(s1y);

         s1x2_ff <= s1x_ff;
         s1y2_ff <= s1y_ff;
         d1x2_ff <= d1x_ff;
         d1y2_ff <= d1y_ff;
         p_a_ff  <= d1x_ff * d2y_ff;
         p_b_ff  <= d1y_ff * d2x_ff;
         p_c_ff  <= ex_ff * d2y_ff;
         p_d_ff  <= ey_ff * d2x_ff;
         p_e_ff  <= d1y_ff * ex_ff;
         p_f_ff  <= d1x_ff * ey_ff;

         s1x3_ff <= s1x2_ff;
         s1y3_ff <= s1y2_ff;
         d1x3_ff <= d1x2_ff;
         d1y3_ff <= d1y2_ff;
         deno_ff <= deno_in;
         snum_ff <= snum_in;
         tnum_ff <= tnum_in;

         s1x4_ff     <= s1x3_ff;
         s1y4_ff     <= s1y3_ff;
         d1x_mag_ff  <= d1x_abs;
         d1y_mag_ff  <= d1y_abs;
         snum_mag_ff <= snum_abs[AW-1:0];
         deno_mag_ff <= deno_abs[AW-1:0];
         neg_x_ff    <= ((snum_ff < 0) != (d1x3_ff < 0)) != (deno_ff < 0);
         neg_y_ff    <= ((snum_ff < 0) != (d1y3_ff < 0)) != (deno_ff < 0);
         par_ff      <= (deno_ff == 0);
         hit_ff      <= s_in_unit && t_in_unit && (deno_ff != 0);

         prod_x_ff <= PW'(snum_mag_ff) * PW'(d1x_mag_ff);
         prod_y_ff <= PW'(snum_mag_ff) * PW'(d1y_mag_ff);
         deno5_ff  <= deno_mag_ff;
         tag_ff    <= {hit_ff, par_ff, neg_x_ff, neg_y_ff, s1x4_ff, s1y4_ff};
      end
   end

   assign out_valid = vld_ff[4];
   assign prod_x    = prod_x_ff;
   assign prod_y    = prod_y_ff;
   assign deno_mag  = deno5_ff;
   assign tag       = tag_ff;

endmodule

// ===== hdl/seg_isect_div.sv =====
`timescale 1ns / 1ps
module seg_isect_div #(
   parameter int COORD_WIDTH = seg_isect_pkg::COORD_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         in_valid,
   input  logic [3*(COORD_WIDTH+1)-1:0] num_x,
   input  logic [3*(COORD_WIDTH+1)-1:0] num_y,
   input  logic [2*(COORD_WIDTH+1)-1:0] den,
   input  logic [2*COORD_WIDTH+3:0]     in_tag,
   output logic                         out_valid,
   output logic [3*(COORD_WIDTH+1)-1:0] quo_x,
   output logic [3*(COORD_WIDTH+1)-1:0] quo_y,
   output logic [2*COORD_WIDTH+3:0]     out_tag
);
   import seg_isect_pkg::*;

   localparam int DW  = COORD_WIDTH + 1;
   localparam int AW  = 2 * DW;
   localparam int PW  = 3 * DW;
   localparam int TW  = 2 * COORD_WIDTH + 4;

   // one quotient bit per stage; the dividend shifts out as the quotient shifts in
   logic [PW:1]     vld_ff;
   logic [AW-1:0]   rx_ff  [1:PW];
   logic [AW-1:0]   ry_ff  [1:PW];
   logic [PW-1:0]   nx_ff  [1:PW];
   logic [PW-1:0]   ny_ff  [1:PW];
   logic [AW-1:0]   d_ff   [1:PW];
   logic [TW-1:0]   tag_ff [1:PW];

   for (genvar k = 0; k < PW; k++) begin : g_step
      logic          v_cur;
      logic [AW-1:0] rx_cur, ry_cur, d_cur;
      logic [PW-1:0] nx_cur, ny_cur;
      logic [TW-1:0] tag_cur;
      logic [AW:0]   tx, ty;
      logic          gex, gey;
      logic [AW:0]   subx, suby;

      // take stage inputs from the ports or from the previous stage
      if (k == 0) begin : g_head
         assign v_cur   = in_valid;
         assign rx_cur  = '0;
         assign ry_cur  = '0;
         assign nx_cur  = num_x;
         assign ny_cur  = num_y;
         assign d_cur   = den;
         assign tag_cur = in_tag;
      end else begin : g_body
         assign v_cur   = vld_ff[k];
         assign rx_cur  = rx_ff[k];
         assign ry_cur  = ry_ff[k];
         assign nx_cur  = nx_ff[k];
         assign ny_cur  = ny_ff[k];
         assign d_cur   = d_ff[k];
         assign tag_cur = tag_ff[k];
      end

      assign tx   = {rx_cur, nx_cur[PW-1]};
      assign ty   = {ry_cur, ny_cur[PW-1]};
      assign gex  = tx >= {1'b0, d_cur};
      assign gey  = ty >= {1'b0, d_cur};
      assign subx = gex ? tx - {1'b0, d_cur} : tx;
      assign suby = gey ? ty - {1'b0, d_cur} : ty;

      // advance valid bit
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else if (en) begin
            vld_ff[k+1] <= v_cur;
         end
      end

      // advance remainders, quotient bits and side data
      always_ff @(posedge clock) begin
         if (en) begin
            rx_ff[k+1]  <= subx[AW-1:0];
            ry_ff[k+1]  <= suby[AW-1:0];
            nx_ff[k+1]  <= {nx_cur[PW-2:0], gex};
            ny_ff[k+1]  <= {ny_cur[PW-2:0], gey};
            d_ff[k+1]   <= d_cur;
            tag_ff[k+1] <= tag_cur;
         end
      end
   end

   assign out_valid = vld_ff[PW];
   assign quo_x     = nx_ff[PW];
   assign quo_y     = ny_ff[PW];
   assign out_tag   = tag_ff[PW];

endmodule

// ===== hdl/segment_intersection_test.sv =====
`timescale 1ns / 1ps
// Path: each input beat passes through the front-end stages, then the bit-per-stage pipelined divider
// that forms the point coordinates, then the result register.
// Throughput: one beat per cycle; a stalled result holds the whole pipeline.
// Reset: synchronous, active high; clears all valid bits, no data is reset.
module segment_intersection_test #(
   parameter int COORD_WIDTH = seg_isect_pkg::COORD_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [COORD_WIDTH-1:0] req_first_start_x,
   input  logic signed [COORD_WIDTH-1:0] req_first_start_y,
   input  logic signed [COORD_WIDTH-1:0] req_first_end_x,
   input  logic signed [COORD_WIDTH-1:0] req_first_end_y,
   input  logic signed [COORD_WIDTH-1:0] req_second_start_x,
   input  logic signed [COORD_WIDTH-1:0] req_second_start_y,
   input  logic signed [COORD_WIDTH-1:0] req_second_end_x,
   input  logic signed [COORD_WIDTH-1:0] req_second_end_y,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_hit,
   output logic                          rsp_parallel,
   output logic signed [COORD_WIDTH-1:0] rsp_point_x,
   output logic signed [COORD_WIDTH-1:0] rsp_point_y,
   output logic                          rsp_point_saturated
);
   import seg_isect_pkg::*;

   localparam int W  = COORD_WIDTH;
   localparam int DW = W + 1;
   localparam int AW = 2 * DW;
   localparam int PW = 3 * DW;
   localparam int TW = 2 * W + 4;
   localparam int SW = PW + 2;

   logic          en;
   logic          f_valid, d_valid;
   logic [PW-1:0] f_px, f_py, q_x, q_y;
   logic [AW-1:0] f_den;
   logic [TW-1:0] f_tag, d_tag;

   logic          hit_ff, par_ff, sat_ff, vld_ff;
   logic [W-1:0]  px_ff, py_ff;
   logic [W-1:0]  px_in, py_in;
   logic          satx, saty;

   // move everything when the result register is free or being taken
   assign en        = !(vld_ff && rsp_stall);
   assign req_stall = !en;

   seg_isect_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .s1x       (req_first_start_x),
      .s1y       (req_first_start_y),
      .e1x       (req_first_end_x),
      .e1y       (req_first_end_y),
      .s2x       (req_second_start_x),
      .s2y       (req_second_start_y),
      .e2x       (req_second_end_x),
      .e2y       (req_second_end_y),
      .out_valid (f_valid),
      .prod_x    (f_px),
      .prod_y    (f_py),
      .deno_mag  (f_den),
      .tag       (f_tag)
   );

   seg_isect_div #(.COORD_WIDTH(COORD_WIDTH)) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (f_valid),
      .num_x     (f_px),
      .num_y     (f_py),
      .den       (f_den),
      .in_tag    (f_tag),
      .out_valid (d_valid),
      .quo_x     (q_x),
      .quo_y     (q_y),
      .out_tag   (d_tag)
   );

   // add signed quotient to start point and clip to coordinate range
   function automatic logic [W:0] clip(input logic [W-1:0] start, input logic neg,
                                       input logic [PW-1:0] q);
      logic signed [SW-1:0] sum;
      logic signed [SW-1:0] maxv;
      logic signed [SW-1:0] minv;
      logic [W:0]           res;
      maxv = SW'((64'sd1 <<< (W - 1)) - 1);
      minv = -maxv - SW'(1);
      sum  = SW'($signed(start)) + (neg ? -$signed({2'b00, q}) : $signed({2'b00, q}));
      if (sum > maxv) begin
         res = {1'b1, maxv[W-1:0]};
      end else if (sum < minv) begin
         res = {1'b1, minv[W-1:0]};
      end else begin
         res = {1'b0, sum[W-1:0]};
      end
      return res;
   endfunction

   always_comb begin
      {satx, px_in} = clip(d_tag[2*W-1:W], d_tag[2*W+1], q_x);
      {saty, py_in} = clip(d_tag[W-1:0], d_tag[2*W], q_y);
   end

   // hold result register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= d_valid;
      end
   end

   // load result; zero the point for parallel pairs
   always_ff @(posedge clock) begin
      if (en) begin
         hit_ff <= d_tag[2*W+3];
         par_ff <= d_tag[2*W+2];
         px_ff  <= d_tag[2*W+2] ? '0 : px_in;
         py_ff  <= d_tag[2*W+2] ? '0 : py_in;
         sat_ff <= d_tag[2*W+2] ? 1'b0 : (satx || saty);
      end
   end

   assign rsp_valid           = vld_ff;
   assign rsp_hit             = hit_ff;
   assign rsp_parallel        = par_ff;
   assign rsp_point_x         = px_ff;
   assign rsp_point_y         = py_ff;
   assign rsp_point_saturated = sat_ff;

endmodule
